// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising edge outside of reset.
`define FTS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fts assertion failed");
// The condition must never be true outside of reset.
`define FTS_ASSERT_NEVER(label, clk, rst, cond) \
  `FTS_ASSERT(label, clk, rst, !(cond))
`else
`define FTS_ASSERT(label, clk, rst, prop)
`define FTS_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg
// Types, constants and helpers shared by the message queue with type search.
// ----------------------------------------------------------------------------
`default_nettype none

package fts_pkg;

  // Number of ring slots and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Field types of one message.
  typedef logic [1:0]  req_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] uid_t;
  typedef logic [31:0] stamp_t;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_SHIFT = 2'd1,
    REQ_PEEK  = 2'd2
  } req_code_t;

  // One stored message.
  typedef struct packed {
    byte_t  msg_type;
    uid_t   uid;
    byte_t  source;
    byte_t  target;
    byte_t  param_a;
    byte_t  param_b;
    byte_t  param_c;
    stamp_t client_end;
    stamp_t client_start;
    stamp_t server_end;
    stamp_t server_start;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic push;
    logic pop;
    logic scan_start;
    logic scan_step;
    logic load_out;
    logic out_from_mem;
    logic out_hit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic full;
    logic out_free;
    logic scan_hit;
    logic scan_miss;
  } status_t;

  // Ring pointer increment with wrap at DEPTH.
  function automatic idx_t idx_inc(input idx_t i);
    idx_t r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fts_if.sv =====
// ----------------------------------------------------------------------------
// fts_req_if / fts_rsp_if
// Valid/ready channels for requests into and results out of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface fts_req_if;
  import fts_pkg::*;

  logic   valid;
  logic   ready;
  req_t   req_type;
  byte_t  msg_type;
  uid_t   msg_uid;
  byte_t  msg_source;
  byte_t  msg_target;
  byte_t  param_a;
  byte_t  param_b;
  byte_t  param_c;
  stamp_t client_end_time;
  stamp_t client_start_time;
  stamp_t server_end_time;
  stamp_t server_start_time;

  modport source (
    output valid, req_type, msg_type, msg_uid, msg_source, msg_target,
           param_a, param_b, param_c, client_end_time, client_start_time,
           server_end_time, server_start_time,
    input  ready
  );

  modport sink (
    input  valid, req_type, msg_type, msg_uid, msg_source, msg_target,
           param_a, param_b, param_c, client_end_time, client_start_time,
           server_end_time, server_start_time,
    output ready
  );
endinterface

interface fts_rsp_if;
  import fts_pkg::*;

  logic   valid;
  logic   ready;
  logic   hit;
  byte_t  out_type;
  uid_t   out_uid;
  byte_t  out_source;
  byte_t  out_target;
  byte_t  out_param_a;
  byte_t  out_param_b;
  byte_t  out_param_c;
  stamp_t out_client_end;
  stamp_t out_client_start;
  stamp_t out_server_end;
  stamp_t out_server_start;

  modport source (
    output valid, hit, out_type, out_uid, out_source, out_target,
           out_param_a, out_param_b, out_param_c, out_client_end,
           out_client_start, out_server_end, out_server_start,
    input  ready
  );

  modport sink (
    input  valid, hit, out_type, out_uid, out_source, out_target,
           out_param_a, out_param_b, out_param_c, out_client_end,
           out_client_start, out_server_end, out_server_start,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/fts_ctrl.sv =====
// ----------------------------------------------------------------------------
// fts_ctrl
// Sequencer of the queue: takes one request at a time, starts the push or
// the ring scan, and decides when the result register is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  fts_pkg::status_t status,
  output fts_pkg::cmd_t    cmd
);
  import fts_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          unique case (req_code_t'(status.req))
            REQ_SHIFT, REQ_PEEK: state_next = ST_SCAN;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (status.scan_hit || status.scan_miss) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        // The result register must be free before anything changes.
        if (status.out_free) begin
          unique case (req_code_t'(status.req))
            REQ_PUSH: begin
              cmd.push     = !status.full;
              cmd.load_out = 1'b1;
              cmd.out_hit  = !status.full;
            end
            REQ_SHIFT, REQ_PEEK: begin
              cmd.scan_start = 1'b1;
            end
            default: begin
              cmd.load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_hit) begin
          cmd.load_out     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_hit      = 1'b1;
          cmd.pop          = (req_code_t'(status.req) == REQ_SHIFT);
        end else if (status.scan_miss) begin
          cmd.load_out = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fts_datapath.sv =====
// ----------------------------------------------------------------------------
// fts_datapath
// Message ring memory, head/tail pointers, occupancy count, scan pipeline
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_datapath (
  input  wire              clk,
  input  wire              rst,
  input  fts_pkg::req_t    in_req,
  input  fts_pkg::entry_t  in_entry,
  input  fts_pkg::cmd_t    cmd,
  output fts_pkg::status_t status,
  input  wire              out_ready,
  output logic             out_valid,
  output logic             out_hit,
  output fts_pkg::entry_t  out_entry
);
  import fts_pkg::*;

  localparam logic [IDX_W:0] DEPTH_WIDE = (IDX_W + 1)'(DEPTH);

  // Ring storage.
  entry_t mem [DEPTH];

  // Captured request.
  req_t   item_req;
  entry_t item;

  // Ring pointers and occupancy.
  idx_t head;
  idx_t tail;
  cnt_t count;

  // Scan pipeline: issue counter, its limit and the registered read.
  cnt_t   issue_k;
  cnt_t   scan_limit;
  logic   rd_valid;
  entry_t rd_data;

  logic           issue_more;
  logic [IDX_W:0] rd_sum;
  logic [IDX_W:0] rd_wrap;
  idx_t           rd_addr;

  // Address of the next entry to read, counted from the head with wrap.
  always_comb begin
    issue_more = cmd.scan_step && (issue_k < scan_limit);
    rd_sum     = {1'b0, head} + {1'b0, issue_k[IDX_W-1:0]};
    rd_wrap    = (rd_sum >= DEPTH_WIDE) ? (rd_sum - DEPTH_WIDE) : rd_sum;
    rd_addr    = rd_wrap[IDX_W-1:0];
  end

  // Status toward the controller.
  always_comb begin
    status.req       = item_req;
    status.full      = (count == CNT_W'(DEPTH));
    status.out_free  = !out_valid || out_ready;
    status.scan_hit  = rd_valid &&
                       ((req_code_t'(item_req) == REQ_SHIFT) ||
                        (rd_data.msg_type == item.msg_type));
    status.scan_miss = !rd_valid && (issue_k == scan_limit);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      issue_k    <= '0;
      scan_limit <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        tail  <= idx_inc(tail);
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        head  <= idx_inc(head);
        count <= count - CNT_W'(1);
      end

      // A shift looks at the head entry only; a peek at every stored one.
      if (cmd.scan_start) begin
        issue_k  <= '0;
        rd_valid <= 1'b0;
        if (req_code_t'(item_req) == REQ_SHIFT) begin
          scan_limit <= (count != '0) ? CNT_W'(1) : '0;
        end else begin
          scan_limit <= count;
        end
      end else if (cmd.scan_step) begin
        rd_valid <= issue_more;
        if (issue_more) begin
          issue_k <= issue_k + CNT_W'(1);
        end
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, ring write and read, result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_req <= in_req;
      item     <= in_entry;
    end
    if (cmd.push) begin
      mem[tail] <= item;
    end
    if (issue_more) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.load_out) begin
      out_hit   <= cmd.out_hit;
      out_entry <= cmd.out_from_mem ? rd_data : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fifo_with_type_search_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_with_type_search_unit
// Bounded message queue with push, shift of the oldest message and a peek
// that returns the oldest stored message of a given type.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Contents
//   --------+-----------+------------------------------------------------
//   req     | in        | req_type, message type/id/nodes/params/stamps
//   rsp     | out       | hit and the fields of the returned message
//
// One request is in work at a time. A push writes the ring unless it is full
// and loads its result; a shift reads the head entry, and a peek scans from
// the head to the first match or through all stored entries on a miss: the
// scan reads one entry a cycle. Reset empties the queue; the ring contents
// need no clearing. A new beat is taken while a result waits, but a stalled
// result delays its execution.
`default_nettype none
`include "assert_macros.svh"

module fifo_with_type_search_unit (
  input  wire       clk,
  input  wire       rst,
  fts_req_if.sink   req,
  fts_rsp_if.source rsp
);
  import fts_pkg::*;

  cmd_t    cmd;
  status_t status;
  entry_t  in_entry;
  entry_t  out_entry;
  logic    in_ready;
  logic    out_valid;
  logic    out_hit;

  // Pack the request beat into one message.
  always_comb begin
    in_entry.msg_type     = req.msg_type;
    in_entry.uid          = req.msg_uid;
    in_entry.source       = req.msg_source;
    in_entry.target       = req.msg_target;
    in_entry.param_a      = req.param_a;
    in_entry.param_b      = req.param_b;
    in_entry.param_c      = req.param_c;
    in_entry.client_end   = req.client_end_time;
    in_entry.client_start = req.client_start_time;
    in_entry.server_end   = req.server_end_time;
    in_entry.server_start = req.server_start_time;
  end

  assign req.ready = in_ready;

  fts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_req    (req.req_type),
    .in_entry  (in_entry),
    .cmd       (cmd),
    .status    (status),
    .out_ready (rsp.ready),
    .out_valid (out_valid),
    .out_hit   (out_hit),
    .out_entry (out_entry)
  );

  // Drive the result channel from the result register.
  always_comb begin
    rsp.valid            = out_valid;
    rsp.hit              = out_hit;
    rsp.out_type         = out_entry.msg_type;
    rsp.out_uid          = out_entry.uid;
    rsp.out_source       = out_entry.source;
    rsp.out_target       = out_entry.target;
    rsp.out_param_a      = out_entry.param_a;
    rsp.out_param_b      = out_entry.param_b;
    rsp.out_param_c      = out_entry.param_c;
    rsp.out_client_end   = out_entry.client_end;
    rsp.out_client_start = out_entry.client_start;
    rsp.out_server_end   = out_entry.server_end;
    rsp.out_server_start = out_entry.server_start;
  end

  // A push is never written into a full ring.
  `FTS_ASSERT(a_push_not_full, clk, rst, cmd.push |-> !status.full)
  // A scan never reports a match and a miss together.
  `FTS_ASSERT_NEVER(a_hit_miss_excl, clk, rst, status.scan_hit && status.scan_miss)
  // The result register is loaded only when its previous beat is gone.
  `FTS_ASSERT(a_load_when_free, clk, rst, cmd.load_out |-> status.out_free)
  // After an accepted request beat, no other beat is taken in the next cycle.
  `FTS_ASSERT(a_one_in_work, clk, rst, (req.valid && req.ready) |=> !req.ready)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the message queue with type search. Requests
// (push, shift, peek by type and the unused code) go in on the request
// channel. A ring model of the queue predicts each reply, and every reply
// beat is compared field by field against the oldest pending prediction.
// Both channels idle at random. One long receiver stall fills the block,
// and drains make the sender wait until every reply has arrived.
// ----------------------------------------------------------------------------
module tb;
  import fts_pkg::*;

  localparam req_t REQ_UNUSED     = 2'd3;
  localparam int   CLK_HALF       = 4;
  localparam int   RESET_CYCLES   = 11;
  localparam int   RANDOM_ITEMS   = 425;
  localparam int   LONG_HOLD      = 64;
  localparam int   SETTLE_CYCLES  = 40;
  localparam int   WATCHDOG_LIMIT = 1000;

  // One reply beat: the hit flag and the returned message.
  typedef struct packed {
    logic   hit;
    entry_t msg;
  } reply_t;

  // --------------------------------------------------------------------------
  // Ring model of the queue and the list of replies still owed.
  // --------------------------------------------------------------------------
  class msg_queue_book;
    entry_t      ring[DEPTH];
    idx_t        head;
    idx_t        tail;
    cnt_t        count;
    reply_t      owed[$];
    int unsigned errors;
    int unsigned n_req, n_push, n_drop, n_shift, n_peek, n_peek_hit, n_unused;

    function new();
      head = '0;
      tail = '0;
      count = '0;
    endfunction

    function idx_t next_slot(input idx_t i);
      return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    // Work out the reply that one accepted request beat must cause.
    function void note_request(input req_t code, input entry_t msg);
      reply_t r;
      idx_t   slot;
      r = '0;
      n_req++;
      case (code)
        REQ_PUSH: begin
          n_push++;
          if (count < cnt_t'(DEPTH)) begin
            ring[tail] = msg;
            tail = next_slot(tail);
            count++;
            r.hit = 1'b1;
          end else begin
            n_drop++;
          end
        end
        REQ_SHIFT: begin
          n_shift++;
          if (count != 0) begin
            r.hit = 1'b1;
            r.msg = ring[head];
            head = next_slot(head);
            count--;
          end
        end
        REQ_PEEK: begin
          n_peek++;
          slot = head;
          for (int k = 0; k < int'(count); k++) begin
            if (ring[slot].msg_type == msg.msg_type) begin
              r.hit = 1'b1;
              r.msg = ring[slot];
              n_peek_hit++;
              break;
            end
            slot = next_slot(slot);
          end
        end
        default: begin
          n_unused++;
        end
      endcase
      owed.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one reply beat against the oldest owed reply.
    function void check_result(input reply_t got);
      reply_t want;
      if (owed.size() == 0) begin
        $error("reply beat with no request waiting for it");
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("out_type", want.msg.msg_type, got.msg.msg_type);
      compare_field("out_uid", want.msg.uid, got.msg.uid);
      compare_field("out_source", want.msg.source, got.msg.source);
      compare_field("out_target", want.msg.target, got.msg.target);
      compare_field("out_param_a", want.msg.param_a, got.msg.param_a);
      compare_field("out_param_b", want.msg.param_b, got.msg.param_b);
      compare_field("out_param_c", want.msg.param_c, got.msg.param_c);
      compare_field("out_client_end", want.msg.client_end, got.msg.client_end);
      compare_field("out_client_start", want.msg.client_start, got.msg.client_start);
      compare_field("out_server_end", want.msg.server_end, got.msg.server_end);
      compare_field("out_server_start", want.msg.server_start, got.msg.server_start);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  fts_req_if req_ch ();
  fts_rsp_if rsp_ch ();

  fifo_with_type_search_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  msg_queue_book book = new();

  bit tx_gaps_on;
  bit rx_gaps_on;
  bit rx_hold_req;
  int rx_stall;
  int idle_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Gap length: mostly short, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Message with random contents and the given type.
  function automatic entry_t random_message(input byte_t ty);
    entry_t m;
    m.msg_type = ty;
    m.uid = uid_t'($urandom);
    m.source = byte_t'($urandom);
    m.target = byte_t'($urandom);
    m.param_a = byte_t'($urandom);
    m.param_b = byte_t'($urandom);
    m.param_c = byte_t'($urandom);
    m.client_end = $urandom;
    m.client_start = $urandom;
    m.server_end = $urandom;
    m.server_start = $urandom;
    return m;
  endfunction

  // Offer one request beat and hold it until the block takes it.
  // Called and left at a falling edge.
  task automatic send_request(input req_t code, input entry_t m);
    req_ch.req_type <= code;
    req_ch.msg_type <= m.msg_type;
    req_ch.msg_uid <= m.uid;
    req_ch.msg_source <= m.source;
    req_ch.msg_target <= m.target;
    req_ch.param_a <= m.param_a;
    req_ch.param_b <= m.param_b;
    req_ch.param_c <= m.param_c;
    req_ch.client_end_time <= m.client_end;
    req_ch.client_start_time <= m.client_start;
    req_ch.server_end_time <= m.server_end;
    req_ch.server_start_time <= m.server_start;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Sender pauses until every owed reply has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (book.pending() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rx_gaps_on && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
      end
    end
  end

  // Monitor on the rising edge: record requests, check replies, watchdog.
  always @(posedge clk) begin : monitor
    reply_t got;
    if (!rst) begin
      idle_cycles++;
      if (req_ch.valid && req_ch.ready) begin
        idle_cycles = 0;
        book.note_request(req_ch.req_type, {req_ch.msg_type, req_ch.msg_uid,
          req_ch.msg_source, req_ch.msg_target, req_ch.param_a, req_ch.param_b,
          req_ch.param_c, req_ch.client_end_time, req_ch.client_start_time,
          req_ch.server_end_time, req_ch.server_start_time});
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        idle_cycles = 0;
        got.hit = rsp_ch.hit;
        got.msg = {rsp_ch.out_type, rsp_ch.out_uid, rsp_ch.out_source,
          rsp_ch.out_target, rsp_ch.out_param_a, rsp_ch.out_param_b,
          rsp_ch.out_param_c, rsp_ch.out_client_end, rsp_ch.out_client_start,
          rsp_ch.out_server_end, rsp_ch.out_server_start};
        book.check_result(got);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired with %0d replies owed", book.pending());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    entry_t m;
    req_t   code;
    int     r;
    int     push_pct;
    byte_t  ty;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PUSH;
    req_ch.msg_type = '0;
    req_ch.msg_uid = '0;
    req_ch.msg_source = '0;
    req_ch.msg_target = '0;
    req_ch.param_a = '0;
    req_ch.param_b = '0;
    req_ch.param_c = '0;
    req_ch.client_end_time = '0;
    req_ch.client_start_time = '0;
    req_ch.server_end_time = '0;
    req_ch.server_start_time = '0;
    rsp_ch.ready = 1'b0;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    rx_hold_req = 1'b0;
    rx_stall = 0;
    idle_cycles = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: requests on an empty queue and the unused code.
    send_request(REQ_SHIFT, random_message(8'd0));
    send_request(REQ_PEEK, random_message(8'd0));
    send_request(REQ_UNUSED, random_message(8'hFF));

    // Directed: all-zero and all-ones messages, then peeks that hit behind the
    // head, hit at the head and miss.
    send_request(REQ_PUSH, '0);
    send_request(REQ_PUSH, '1);
    send_request(REQ_PEEK, random_message(8'hFF));
    send_request(REQ_PEEK, random_message(8'h00));
    send_request(REQ_PEEK, random_message(8'h07));

    // Directed: fill the ring, push once more while it is full, then find
    // the entry at the far end of the ring and take two off the head.
    for (int i = 0; i < DEPTH - 3; i++) begin
      send_request(REQ_PUSH, random_message(byte_t'($urandom_range(1, 5))));
    end
    send_request(REQ_PUSH, random_message(8'd200));
    send_request(REQ_PUSH, random_message(8'd201));
    send_request(REQ_PEEK, random_message(8'd200));
    send_request(REQ_SHIFT, random_message(8'd0));
    send_request(REQ_SHIFT, random_message(8'd0));
    wait_drained();

    // Random: mostly well-formed traffic over a small set of types so that
    // peeks find matches, with moods that drive the ring toward full or
    // empty, and a little noise from the unused code and wide types.
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    push_pct = 55;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) push_pct = (push_pct == 55) ? 25 : 55;
      if (n == 150) begin
        // Long receiver hold while the sender keeps offering beats.
        rx_hold_req = 1'b1;
        tx_gaps_on = 1'b0;
      end
      if (n == 190) tx_gaps_on = 1'b1;
      if (n == 210) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
      end
      if (n == 270) begin
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
      end
      if (n == 320) wait_drained();

      ty = ($urandom_range(0, 7) == 0) ? byte_t'($urandom) : byte_t'($urandom_range(0, 5));
      r = $urandom_range(0, 99);
      if (r < 3) code = REQ_UNUSED;
      else if (r < 3 + push_pct) code = REQ_PUSH;
      else if (r < 33 + push_pct) code = REQ_PEEK;
      else code = REQ_SHIFT;
      m = random_message(ty);

      if (tx_gaps_on && $urandom_range(0, 2) == 0) idle_sender(pick_gap());
      send_request(code, m);
    end

    // Let the last replies arrive, then watch for stray beats.
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (book.pending() != 0) begin
      $error("%0d replies never arrived", book.pending());
      book.errors++;
    end

    $display("tb: %0d requests: %0d pushes (%0d dropped on a full ring), %0d shifts,",
             book.n_req, book.n_push, book.n_drop, book.n_shift);
    $display("tb: %0d peeks (%0d found a match), %0d unused codes, %0d mismatches",
             book.n_peek, book.n_peek_hit, book.n_unused, book.errors);
    if (book.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
